### sv/intrusion_alarm_mode_controller_macros.svh
// Assertion macros shared by the alarm controller checker.
`ifndef INTRUSION_ALARM_MODE_CONTROLLER_MACROS_SVH
`define INTRUSION_ALARM_MODE_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IAMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IAMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/iamc_pkg.sv
// Types and fixed constants of the intrusion alarm mode controller.
`default_nettype none

package iamc_pkg;

    localparam int unsigned OP_W        = 4;
    localparam int unsigned EV_W        = 5;
    localparam int unsigned SECS_W      = 7;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned DELAY_W     = 7;
    localparam int unsigned SHOWN_W     = 8;
    localparam int unsigned IN_W        = 9;
    localparam int unsigned OUT_W       = 19;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 24;

    // Time in mode saturates at the top of a 17-bit count.
    localparam int unsigned ELAPSED_MAX = 131071;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 7'd30;
    localparam logic [SHOWN_W-1:0] SHOWN_NONE  = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 4'd0,
        OP_DOOR       = 4'd1,
        OP_WINDOW     = 4'd2,
        OP_MOTION     = 4'd3,
        OP_EXIT_BTN   = 4'd4,
        OP_ARM_FULL   = 4'd5,
        OP_ARM_HOME   = 4'd6,
        OP_DISARM     = 4'd7,
        OP_CANCEL     = 4'd8,
        OP_FACE_MATCH = 4'd9,
        OP_FACE_NO    = 4'd10,
        OP_STATUS     = 4'd11
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE  = 3'd0,
        MODE_EXIT  = 3'd1,
        MODE_FULL  = 3'd2,
        MODE_HOME  = 3'd3,
        MODE_ENTRY = 3'd4,
        MODE_FACE  = 3'd5,
        MODE_ALARM = 3'd6
    } mode_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE          = 5'd0,
        EV_DOOR_ENTRY    = 5'd1,
        EV_WINDOW_ENTRY  = 5'd2,
        EV_MOTION_ALARM  = 5'd3,
        EV_TIMEOUT_ALARM = 5'd4,
        EV_FACE_REQUEST  = 5'd5,
        EV_ENTRY_COUNT   = 5'd6,
        EV_EXIT_COUNT    = 5'd7,
        EV_ARM_FAILED    = 5'd8,
        EV_ARMED_FULL    = 5'd9,
        EV_REJ_NOT_IDLE  = 5'd10,
        EV_REJ_OPEN      = 5'd11,
        EV_EXIT_DELAY    = 5'd12,
        EV_ARMED_HOME    = 5'd13,
        EV_PIN_BARRED    = 5'd14,
        EV_DISARMED      = 5'd15,
        EV_LOCKOUT       = 5'd16,
        EV_WRONG_PIN     = 5'd17,
        EV_NOT_IN_ALARM  = 5'd18,
        EV_CANCELLED     = 5'd19,
        EV_FACE_DISARMED = 5'd20,
        EV_FACE_FAILED   = 5'd21,
        EV_MODE_REPORT   = 5'd22
    } event_t;

    // Input item, first field in the highest bits.
    typedef struct packed {
        logic lockout_begins;
        logic pin_barred;
        logic pin_match;
        logic window_ajar;
        logic door_ajar;
        op_t  op;
    } in_item_t;

    // Result item, first field in the highest bits.
    typedef struct packed {
        logic              bolt_locked;
        logic              siren_on;
        logic              green_lamp;
        logic              red_lamp;
        mode_t             mode_now;
        logic [SECS_W-1:0] seconds_left;
        event_t            event_res;
    } out_item_t;

endpackage

`default_nettype wire

### sv/intrusion_alarm_mode_controller.sv
// Intrusion alarm mode controller: one event item in, one result item out.
// The result of an item is registered and is on m_tdata in the cycle after it is accepted.
// Throughput: one item per cycle; a new item can enter in the cycle in which the
// previous result is taken, so only a stalled result blocks the input.
// Reset: idle mode, timers cleared, green lamp on, bolt locked, delay 30 s.
`default_nettype none

module intrusion_alarm_mode_controller #(
    parameter int unsigned FLASH_PERIOD_MS  = 400,
    parameter int unsigned TICKS_PER_SECOND = 1000
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [iamc_pkg::DELAY_W-1:0]       cfg_wdata,   // delay_seconds
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // op[3:0], door_ajar[4], window_ajar[5], pin_match[6], pin_barred[7],
    // lockout_begins[8], zero fill above
    input  logic [iamc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // event_res[4:0], seconds_left[11:5], mode_now[14:12], red_lamp[15],
    // green_lamp[16], siren_on[17], bolt_locked[18], zero fill above
    output logic [iamc_pkg::M_TDATA_W-1:0]     m_tdata
);

    import iamc_pkg::*;

    // Time in mode is held as whole seconds plus milliseconds in the second.
    localparam int unsigned SEC_MAX = ELAPSED_MAX / TICKS_PER_SECOND;
    localparam int unsigned MS_MAX  = ELAPSED_MAX % TICKS_PER_SECOND;
    localparam int unsigned SEC_W   = $clog2(SEC_MAX + 1);
    localparam int unsigned MS_W    = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int unsigned CMP_W   = (SEC_W > DELAY_W) ? SEC_W : DELAY_W;
    localparam int unsigned FL_W    = $clog2(FLASH_PERIOD_MS + 1);

    localparam logic [SEC_W-1:0] SEC_SAT   = SEC_W'(SEC_MAX);
    localparam logic [MS_W-1:0]  MS_SAT    = MS_W'(MS_MAX);
    localparam logic [MS_W-1:0]  MS_WRAP   = MS_W'(TICKS_PER_SECOND - 1);
    localparam logic [FL_W-1:0]  FL_PERIOD = FL_W'(FLASH_PERIOD_MS);

    // State registers
    logic [DELAY_W-1:0] delay_reg;
    mode_t              mode_reg, mode_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [MS_W-1:0]    ms_reg, ms_next;
    logic [FL_W-1:0]    flash_reg, flash_next;
    logic               phase_reg, phase_next;
    logic               red_reg, red_next;
    logic               green_reg, green_next;
    logic               siren_reg, siren_next;
    logic               lock_reg, lock_next;
    logic [SHOWN_W-1:0] last_entry_reg, last_entry_next;
    logic [SHOWN_W-1:0] last_exit_reg, last_exit_next;
    logic               m_tvalid_reg;
    out_item_t          m_item_reg, m_item_next;

    in_item_t           item;
    logic               in_acc;
    logic               tick;
    logic               armed;
    logic [SEC_W-1:0]   sec_tick;
    logic [MS_W-1:0]    ms_tick;
    logic [CMP_W-1:0]   secs_diff;
    logic [SECS_W-1:0]  secs_rem;
    logic [FL_W-1:0]    flash_inc;
    event_t             ev_next;
    logic [SECS_W-1:0]  secs_next;

    assign item     = in_item_t'(s_tdata[IN_W-1:0]);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign tick     = (item.op == OP_TICK);
    assign armed    = (mode_reg == MODE_FULL) || (mode_reg == MODE_HOME);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - OUT_W)'(0), m_item_reg};

    // Advance the time in mode by one tick and work out the whole seconds left.
    always_comb begin
        sec_tick  = sec_reg;
        ms_tick   = ms_reg;
        secs_diff = '0;
        secs_rem  = '0;
        if (!((sec_reg == SEC_SAT) && (ms_reg == MS_SAT))) begin
            if (ms_reg == MS_WRAP) begin
                ms_tick  = '0;
                sec_tick = sec_reg + SEC_W'(1);
            end else begin
                ms_tick = ms_reg + MS_W'(1);
            end
        end
        // Whole seconds left is the delay less the started seconds.
        if (CMP_W'(sec_tick) < CMP_W'(delay_reg)) begin
            secs_diff = CMP_W'(delay_reg) - CMP_W'(sec_tick) - CMP_W'(ms_tick != '0);
            secs_rem  = secs_diff[SECS_W-1:0];
        end
    end

    // Next mode and event code for the item.
    always_comb begin
        mode_next = mode_reg;
        ev_next   = EV_NONE;
        secs_next = '0;
        unique case (item.op)
            OP_TICK: begin
                if ((mode_reg == MODE_ENTRY) || (mode_reg == MODE_FACE)) begin
                    if (secs_rem == '0) begin
                        mode_next = MODE_ALARM;
                        ev_next   = EV_TIMEOUT_ALARM;
                    end else if (SHOWN_W'(secs_rem) != last_entry_reg) begin
                        ev_next   = EV_ENTRY_COUNT;
                        secs_next = secs_rem;
                    end
                end else if (mode_reg == MODE_EXIT) begin
                    if (secs_rem == '0) begin
                        if (item.door_ajar || item.window_ajar) begin
                            mode_next = MODE_IDLE;
                            ev_next   = EV_ARM_FAILED;
                        end else begin
                            mode_next = MODE_FULL;
                            ev_next   = EV_ARMED_FULL;
                        end
                    end else if (SHOWN_W'(secs_rem) != last_exit_reg) begin
                        ev_next   = EV_EXIT_COUNT;
                        secs_next = secs_rem;
                    end
                end
            end
            OP_DOOR: begin
                if (armed) begin
                    mode_next = MODE_ENTRY;
                    ev_next   = EV_DOOR_ENTRY;
                end
            end
            OP_WINDOW: begin
                if (armed) begin
                    mode_next = MODE_ENTRY;
                    ev_next   = EV_WINDOW_ENTRY;
                end
            end
            OP_MOTION: begin
                if (mode_reg == MODE_FULL) begin
                    mode_next = MODE_ALARM;
                    ev_next   = EV_MOTION_ALARM;
                end
            end
            OP_EXIT_BTN: begin
                if ((mode_reg == MODE_ENTRY) || (mode_reg == MODE_ALARM)) begin
                    mode_next = MODE_FACE;
                    ev_next   = EV_FACE_REQUEST;
                end
            end
            OP_ARM_FULL: begin
                if (mode_reg != MODE_IDLE) begin
                    ev_next = EV_REJ_NOT_IDLE;
                end else if (item.door_ajar || item.window_ajar) begin
                    ev_next = EV_REJ_OPEN;
                end else begin
                    mode_next = MODE_EXIT;
                    ev_next   = EV_EXIT_DELAY;
                end
            end
            OP_ARM_HOME: begin
                if (mode_reg != MODE_IDLE) begin
                    ev_next = EV_REJ_NOT_IDLE;
                end else begin
                    mode_next = MODE_HOME;
                    ev_next   = EV_ARMED_HOME;
                end
            end
            OP_DISARM: begin
                if (item.pin_barred) begin
                    ev_next = EV_PIN_BARRED;
                end else if (item.pin_match) begin
                    mode_next = MODE_IDLE;
                    ev_next   = EV_DISARMED;
                end else if (item.lockout_begins) begin
                    ev_next = EV_LOCKOUT;
                end else begin
                    ev_next = EV_WRONG_PIN;
                end
            end
            OP_CANCEL: begin
                if (mode_reg != MODE_ALARM) begin
                    ev_next = EV_NOT_IN_ALARM;
                end else if (item.pin_match) begin
                    mode_next = MODE_IDLE;
                    ev_next   = EV_CANCELLED;
                end else begin
                    ev_next = EV_WRONG_PIN;
                end
            end
            OP_FACE_MATCH: begin
                if ((mode_reg == MODE_FACE) || (mode_reg == MODE_ENTRY) ||
                    (mode_reg == MODE_ALARM)) begin
                    mode_next = MODE_IDLE;
                    ev_next   = EV_FACE_DISARMED;
                end
            end
            OP_FACE_NO: begin
                if (mode_reg == MODE_FACE) begin
                    mode_next = MODE_ENTRY;
                end
                ev_next = EV_FACE_FAILED;
            end
            OP_STATUS: begin
                ev_next = EV_MODE_REPORT;
            end
            default: begin
                ev_next = EV_NONE;
            end
        endcase
    end

    // Timers, drive levels, flash and the result item follow from the event.
    always_comb begin
        sec_next        = tick ? sec_tick : sec_reg;
        ms_next         = tick ? ms_tick : ms_reg;
        flash_inc       = flash_reg;
        phase_next      = phase_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        siren_next      = siren_reg;
        lock_next       = lock_reg;
        last_entry_next = last_entry_reg;
        last_exit_next  = last_exit_reg;

        // Every mode change restarts the time in mode.
        if (mode_next != mode_reg) begin
            sec_next = '0;
            ms_next  = '0;
        end

        if (tick && (flash_reg < FL_PERIOD)) begin
            flash_inc = flash_reg + FL_W'(1);
        end
        flash_next = flash_inc;

        case (ev_next) inside
            EV_MOTION_ALARM, EV_TIMEOUT_ALARM: begin
                siren_next = 1'b1;
                red_next   = 1'b1;
                green_next = 1'b0;
            end
            EV_DISARMED, EV_CANCELLED, EV_FACE_DISARMED: begin
                siren_next = 1'b0;
                lock_next  = 1'b0;
                red_next   = 1'b0;
                green_next = 1'b1;
            end
            EV_EXIT_DELAY: begin
                lock_next  = 1'b1;
                green_next = 1'b0;
            end
            EV_ARMED_HOME: begin
                lock_next  = 1'b1;
                green_next = 1'b1;
            end
            EV_ENTRY_COUNT: begin
                last_entry_next = SHOWN_W'(secs_rem);
            end
            EV_EXIT_COUNT: begin
                last_exit_next = SHOWN_W'(secs_rem);
            end
            default: begin
            end
        endcase

        // The red lamp flashes in entry and alarm modes.
        if (((mode_next == MODE_ALARM) || (mode_next == MODE_ENTRY)) &&
            (flash_inc >= FL_PERIOD)) begin
            phase_next = !phase_reg;
            flash_next = '0;
            red_next   = !phase_reg;
        end

        m_item_next.event_res    = ev_next;
        m_item_next.seconds_left = secs_next;
        m_item_next.mode_now     = mode_next;
        m_item_next.red_lamp     = red_next;
        m_item_next.green_lamp   = green_next;
        m_item_next.siren_on     = siren_next;
        m_item_next.bolt_locked  = lock_next;
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
        end else if (cfg_we) begin
            delay_reg <= cfg_wdata;
        end
    end

    // Controller state, updated on every accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            sec_reg        <= '0;
            ms_reg         <= '0;
            flash_reg      <= '0;
            phase_reg      <= 1'b0;
            red_reg        <= 1'b0;
            green_reg      <= 1'b1;
            siren_reg      <= 1'b0;
            lock_reg       <= 1'b1;
            last_entry_reg <= SHOWN_NONE;
            last_exit_reg  <= SHOWN_NONE;
        end else if (in_acc) begin
            mode_reg       <= mode_next;
            sec_reg        <= sec_next;
            ms_reg         <= ms_next;
            flash_reg      <= flash_next;
            phase_reg      <= phase_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            siren_reg      <= siren_next;
            lock_reg       <= lock_next;
            last_entry_reg <= last_entry_next;
            last_exit_reg  <= last_exit_next;
        end
    end

    // Output register: loads whenever it is empty or being emptied.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule

`default_nettype wire

### sv/iamc_checker.sv
// Port-level checker for the alarm controller, bound to the top level.
`default_nettype none
`include "intrusion_alarm_mode_controller_macros.svh"

module iamc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [iamc_pkg::M_TDATA_W-1:0] m_tdata
);

    import iamc_pkg::*;

    out_item_t view;

    assign view = out_item_t'(m_tdata[OUT_W-1:0]);

    // A stalled result holds.
    `IAMC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Every accepted item gives a result in the next cycle.
    `IAMC_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "accepted item gave no result")

    // During the exit delay the green lamp is off and the bolt is locked.
    `IAMC_ASSERT_SAME(a_exit_drives, aclk, aresetn, m_tvalid && (view.mode_now == MODE_EXIT), !view.green_lamp && view.bolt_locked, "wrong drives in exit delay")

    // A stand-down always lands in idle with everything released.
    `IAMC_ASSERT_SAME(a_stand_down, aclk, aresetn, m_tvalid && ((view.event_res == EV_DISARMED) || (view.event_res == EV_CANCELLED) || (view.event_res == EV_FACE_DISARMED)), (view.mode_now == MODE_IDLE) && !view.siren_on && !view.bolt_locked && view.green_lamp && !view.red_lamp, "stand-down left drives set")

    // Only countdown events report seconds.
    `IAMC_ASSERT_SAME(a_secs_countdown, aclk, aresetn, m_tvalid && (view.seconds_left != '0), (view.event_res == EV_ENTRY_COUNT) || (view.event_res == EV_EXIT_COUNT), "seconds on a non-countdown event")

endmodule

bind intrusion_alarm_mode_controller iamc_checker u_iamc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
